>>> hdl/ws2812_pkg.sv
// Package for the three-line WS2812 driver: item codes, sizes and default timing.
package ws2812_pkg;

  // Number of LED lines driven by the block
  localparam int unsigned NumLines = 3;

  // Width of one stored colour word (green, red, blue)
  localparam int unsigned WordW = 24;

  // Width of one colour channel
  localparam int unsigned ChanW = 8;

  // Default waveform timing, in 50 ns ticks, and bits sent per LED
  localparam int unsigned ShortTicksDefault = 7;
  localparam int unsigned LongTicksDefault  = 18;
  localparam int unsigned BitsPerLedDefault = 24;

  // Brightness after reset
  localparam logic [ChanW-1:0] BrightnessReset = 8'd255;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_SET_ONE = 2'd0,
    MODE_SET_ALL = 2'd1,
    MODE_FLUSH   = 2'd2,
    MODE_TICK    = 2'd3
  } mode_e;

endpackage

>>> hdl/ws2812_three_line_led_driver.sv
// Top level of the three-line WS2812 driver: colour store, pending latches, bit encoders.
//
// Usage
//   Input items arrive on the s_axis channel. tuser gives the item kind: set one LED,
//   set all LEDs, flush, or tick. tdata carries the line index and the red, green and
//   blue channel values. A set item scales each channel by brightness/255 and stores
//   the word; a flush copies every stored word into that line's one-deep pending latch,
//   refusing lines whose latch is still full; a tick advances every line one 50 ns step.
//   Every item produces exactly one result on m_axis: line levels, busy lines and
//   refused-flush flags, all taken from the state after that item. The user must write
//   brightness via brightness_we_i / brightness_i only while the block idles; unenforced.
// Timing
//   One item per clock sustained while m_axis takes results. The pipeline has one stage
//   for the channel multiplications and one for the divide by 255 and the state update,
//   whose result lands in the output register.
// Reset
//   rst_ni clears every line to idle, empties the latches, zeroes the stored words and
//   sets brightness to 255.
// Stall
//   While m_axis is stalled the result is held; one more item may enter the first
//   stage, then s_axis_tready drops until the result is taken.
module ws2812_three_line_led_driver #(
  parameter int unsigned SHORT_TICKS  = ws2812_pkg::ShortTicksDefault,
  parameter int unsigned LONG_TICKS   = ws2812_pkg::LongTicksDefault,
  parameter int unsigned BITS_PER_LED = ws2812_pkg::BitsPerLedDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // brightness register write
  input  logic        brightness_we_i,
  input  logic [7:0]  brightness_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: led_index[1:0], red[9:2], green[17:10], blue[25:18], zero[31:26]
  input  logic [31:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: line_levels[2:0], busy_lines[5:3], flush_refused[8:6], zero[15:9]
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned NumLines = ws2812_pkg::NumLines;
  localparam int unsigned WordW    = ws2812_pkg::WordW;
  localparam int unsigned ChanW    = ws2812_pkg::ChanW;
  localparam int unsigned ProdW    = 2 * ChanW;
  localparam int unsigned Period   = SHORT_TICKS + LONG_TICKS;
  localparam int unsigned TickW    = (Period > 1) ? $clog2(Period) : 1;
  localparam int unsigned BitCntW  = $clog2(BITS_PER_LED + 1);

  localparam logic [TickW:0]     PeriodC   = (TickW+1)'(Period);
  localparam logic [TickW:0]     ShortC    = (TickW+1)'(SHORT_TICKS);
  localparam logic [TickW:0]     TwoShortC = (TickW+1)'(2 * SHORT_TICKS);
  localparam logic [BitCntW-1:0] BitsC     = BitCntW'(BITS_PER_LED);

  // Brightness register
  logic [ChanW-1:0] brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= ws2812_pkg::BrightnessReset;
    end else if (brightness_we_i) begin
      brightness_q <= brightness_i;
    end
  end

  // Stage handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_take;

  assign s2_take       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s2_take;

  // Stage 1: item fields and channel products
  ws2812_pkg::mode_e s1_mode_q;
  logic [1:0]        s1_idx_q;
  logic [ProdW-1:0]  s1_red_q, s1_green_q, s1_blue_q;

  // valid flag and item kind, known from reset so the decoder never sees an unknown kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mode_q  <= ws2812_pkg::MODE_TICK;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        s1_mode_q <= ws2812_pkg::mode_e'(s_axis_tuser);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_idx_q   <= s_axis_tdata[1:0];
      s1_red_q   <= ProdW'(s_axis_tdata[9:2])   * ProdW'(brightness_q);
      s1_green_q <= ProdW'(s_axis_tdata[17:10]) * ProdW'(brightness_q);
      s1_blue_q  <= ProdW'(s_axis_tdata[25:18]) * ProdW'(brightness_q);
    end
  end

  // Divide a 16-bit product by 255: exact for every product of two 8-bit values
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + (ProdW+1)'(1) + (ProdW+1)'(p[ProdW-1:ChanW]);
    return s[ProdW-1:ChanW];
  endfunction

  logic [WordW-1:0] word;
  assign word = {div255(s1_green_q), div255(s1_red_q), div255(s1_blue_q)};

  // Line state
  logic [NumLines-1:0][WordW-1:0]   color_q, color_d;
  logic [NumLines-1:0][WordW-1:0]   pend_q, pend_d;
  logic [NumLines-1:0]              pend_full_q, pend_full_d;
  logic [NumLines-1:0][WordW-1:0]   shift_q, shift_d;
  logic [NumLines-1:0][BitCntW-1:0] bits_q, bits_d;
  logic [NumLines-1:0][TickW-1:0]   tick_q, tick_d;

  logic [NumLines-1:0] levels, busy, refused;

  // Next state and result for the item in stage 1
  always_comb begin
    logic [TickW:0] t_next;
    color_d     = color_q;
    pend_d      = pend_q;
    pend_full_d = pend_full_q;
    shift_d     = shift_q;
    bits_d      = bits_q;
    tick_d      = tick_q;
    refused     = '0;
    t_next      = '0;

    unique case (s1_mode_q)
      ws2812_pkg::MODE_SET_ONE: begin
        if (32'(s1_idx_q) < NumLines) color_d[s1_idx_q] = word;
      end
      ws2812_pkg::MODE_SET_ALL: begin
        for (int i = 0; i < NumLines; i++) color_d[i] = word;
      end
      ws2812_pkg::MODE_FLUSH: begin
        for (int i = 0; i < NumLines; i++) begin
          if (pend_full_q[i]) begin
            refused[i] = 1'b1;
          end else begin
            pend_d[i]      = color_q[i];
            pend_full_d[i] = 1'b1;
          end
        end
      end
      ws2812_pkg::MODE_TICK: begin
        for (int i = 0; i < NumLines; i++) begin
          // advance a sending line; end of bit shifts and counts down
          if (bits_q[i] != '0) begin
            t_next = {1'b0, tick_q[i]} + (TickW+1)'(1);
            if (t_next >= PeriodC) begin
              tick_d[i]  = '0;
              shift_d[i] = {shift_q[i][WordW-2:0], 1'b0};
              bits_d[i]  = bits_q[i] - BitCntW'(1);
            end else begin
              tick_d[i] = t_next[TickW-1:0];
            end
          end
          // idle line with a pending word starts it straight away
          if (bits_d[i] == '0 && pend_full_q[i]) begin
            shift_d[i]     = pend_q[i];
            pend_full_d[i] = 1'b0;
            bits_d[i]      = BitsC;
            tick_d[i]      = '0;
          end
        end
      end
      default: ;
    endcase

    // levels and busy flags from the updated state
    for (int i = 0; i < NumLines; i++) begin
      if (bits_d[i] == '0) begin
        levels[i] = 1'b0;
      end else if ({1'b0, tick_d[i]} < ShortC) begin
        levels[i] = 1'b0;
      end else if ({1'b0, tick_d[i]} < TwoShortC) begin
        levels[i] = 1'b1;
      end else begin
        levels[i] = shift_d[i][WordW-1];
      end
      busy[i] = (bits_d[i] != '0) || pend_full_d[i];
    end
  end

  // State registers, updated when the stage 1 item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= '0;
      pend_q      <= '0;
      pend_full_q <= '0;
      shift_q     <= '0;
      bits_q      <= '0;
      tick_q      <= '0;
    end else if (s2_take) begin
      color_q     <= color_d;
      pend_q      <= pend_d;
      pend_full_q <= pend_full_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      tick_q      <= tick_d;
    end
  end

  // Output register
  logic [8:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take) begin
      result_q <= {refused, busy, levels};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q};

endmodule

>>> dv/ws2812_three_line_led_driver_tb.sv
// Self-checking testbench for the three-line WS2812 driver: directed and random item streams.
module ws2812_three_line_led_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLines   = ws2812_pkg::NumLines;
  localparam int unsigned WordW      = ws2812_pkg::WordW;
  localparam int unsigned ShortTicks = ws2812_pkg::ShortTicksDefault;
  localparam int unsigned BitTicks   = ws2812_pkg::ShortTicksDefault +
                                       ws2812_pkg::LongTicksDefault;
  localparam int unsigned BitsPerLed = ws2812_pkg::BitsPerLedDefault;
  localparam int unsigned PhaseItems = 325;

  typedef struct packed {
    logic [2:0] refused;
    logic [2:0] busy;
    logic [2:0] levels;
  } led_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        brightness_we_i;
  logic [7:0]  brightness_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  // Shadow of the block state
  logic [7:0]         brightness_now;
  logic [WordW-1:0]   color_word   [NumLines];
  logic [WordW-1:0]   pending_word [NumLines];
  logic               pending_full [NumLines];
  logic [WordW-1:0]   shift_word   [NumLines];
  int unsigned        bits_to_send [NumLines];
  int unsigned        tick_pos     [NumLines];

  led_result_t expected_results_q[$];
  int unsigned error_count = 0;
  bit          quiet_stretch = 1'b0;

  ws2812_three_line_led_driver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .brightness_we_i(brightness_we_i),
    .brightness_i   (brightness_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the pipeline locks up
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] scale_channel(logic [7:0] v);
    return 8'((int'(v) * int'(brightness_now)) / 255);
  endfunction

  // Apply one item to the shadow state and return the result it should produce
  function automatic led_result_t predict_led_item(ws2812_pkg::mode_e mode, logic [1:0] idx,
                                                   logic [7:0] r, logic [7:0] g,
                                                   logic [7:0] b);
    led_result_t      res;
    logic [WordW-1:0] word;
    res  = '0;
    word = {scale_channel(g), scale_channel(r), scale_channel(b)};
    case (mode)
      ws2812_pkg::MODE_SET_ONE: begin
        if (idx < NumLines) color_word[idx] = word;
      end
      ws2812_pkg::MODE_SET_ALL: begin
        for (int i = 0; i < NumLines; i++) color_word[i] = word;
      end
      ws2812_pkg::MODE_FLUSH: begin
        for (int i = 0; i < NumLines; i++) begin
          if (pending_full[i]) begin
            res.refused[i] = 1'b1;
          end else begin
            pending_word[i] = color_word[i];
            pending_full[i] = 1'b1;
          end
        end
      end
      default: begin
        // one waveform step; an idle line picks up its pending word with no gap
        for (int i = 0; i < NumLines; i++) begin
          if (bits_to_send[i] != 0) begin
            tick_pos[i]++;
            if (tick_pos[i] >= BitTicks) begin
              tick_pos[i]     = 0;
              shift_word[i]   = shift_word[i] << 1;
              bits_to_send[i]--;
            end
          end
          if (bits_to_send[i] == 0 && pending_full[i]) begin
            shift_word[i]   = pending_word[i];
            pending_full[i] = 1'b0;
            bits_to_send[i] = BitsPerLed;
            tick_pos[i]     = 0;
          end
        end
      end
    endcase
    for (int i = 0; i < NumLines; i++) begin
      if (bits_to_send[i] == 0)          res.levels[i] = 1'b0;
      else if (tick_pos[i] < ShortTicks)     res.levels[i] = 1'b0;
      else if (tick_pos[i] < 2 * ShortTicks) res.levels[i] = 1'b1;
      else                                   res.levels[i] = shift_word[i][WordW-1];
      res.busy[i] = (bits_to_send[i] != 0) || pending_full[i];
    end
    return res;
  endfunction

  // Send one item (random gaps before it unless quiet_stretch) and record its expected result
  task automatic send_item(ws2812_pkg::mode_e mode, logic [1:0] idx, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    while (!quiet_stretch && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'd0, b, g, r, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results_q.push_back(predict_led_item(mode, idx, r, g, b));
  endtask

  // Wait for the block to drain, then write brightness
  task automatic write_brightness(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    brightness_we_i <= 1'b1;
    brightness_i    <= value;
    @(posedge clk_i);
    brightness_we_i <= 1'b0;
    brightness_now = value;
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin : check_result
    led_result_t got;
    led_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[8:0];
      if (expected_results_q.size() == 0) begin
        $display("%0t: unexpected result levels=%b busy=%b refused=%b", $time,
                 got.levels, got.busy, got.refused);
        error_count++;
      end else begin
        want = expected_results_q.pop_front();
        if (got.levels !== want.levels) begin
          $display("%0t: line_levels expected %b got %b", $time, want.levels, got.levels);
          error_count++;
        end
        if (got.busy !== want.busy) begin
          $display("%0t: busy_lines expected %b got %b", $time, want.busy, got.busy);
          error_count++;
        end
        if (got.refused !== want.refused) begin
          $display("%0t: flush_refused expected %b got %b", $time, want.refused,
                   got.refused);
          error_count++;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 9);
  end

  task automatic test_idle_after_reset();
    send_item(ws2812_pkg::MODE_TICK, 2'd0, 8'h00, 8'h00, 8'h00);
    send_item(ws2812_pkg::MODE_TICK, 2'd3, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_set_colours();
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd0, 8'hFF, 8'h00, 8'hFF);
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd1, 8'h00, 8'hFF, 8'h00);
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd2, 8'hA5, 8'h5A, 8'hC3);
    // index three is ignored
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd3, 8'hFF, 8'hFF, 8'hFF);
    send_item(ws2812_pkg::MODE_SET_ALL, 2'd2, 8'h12, 8'h34, 8'h56);
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd1, 8'h80, 8'h01, 8'h7F);
  endtask

  task automatic test_flush_refusal();
    // index and colour fields do nothing on a flush
    send_item(ws2812_pkg::MODE_FLUSH, 2'd3, 8'hFF, 8'hFF, 8'hFF);
    send_item(ws2812_pkg::MODE_FLUSH, 2'd0, 8'h00, 8'h00, 8'h00);
    send_item(ws2812_pkg::MODE_TICK, 2'd1, 8'h00, 8'h00, 8'h00);
    send_item(ws2812_pkg::MODE_TICK, 2'd2, 8'h00, 8'h00, 8'h00);
    send_item(ws2812_pkg::MODE_FLUSH, 2'd1, 8'h00, 8'h00, 8'h00);
    send_item(ws2812_pkg::MODE_FLUSH, 2'd2, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_brightness_scaling();
    write_brightness(8'd0);
    send_item(ws2812_pkg::MODE_SET_ALL, 2'd0, 8'hFF, 8'hFF, 8'hFF);
    write_brightness(8'd1);
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd2, 8'hFF, 8'h80, 8'h01);
    write_brightness(8'd128);
    send_item(ws2812_pkg::MODE_SET_ONE, 2'd0, 8'hFF, 8'hFE, 8'h02);
    send_item(ws2812_pkg::MODE_TICK, 2'd0, 8'h00, 8'h00, 8'h00);
  endtask

  function automatic logic [7:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5)  return 8'h00;
    if (sel < 10) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Mostly ticks so words go out in full; sets and flushes keep latches busy
  task automatic test_random_traffic(logic [7:0] level, bit no_idling);
    int unsigned       sel;
    ws2812_pkg::mode_e mode;
    write_brightness(level);
    quiet_stretch = no_idling;
    for (int n = 0; n < PhaseItems; n++) begin
      sel = $urandom_range(99);
      if (sel < 7)       mode = ws2812_pkg::MODE_SET_ONE;
      else if (sel < 12) mode = ws2812_pkg::MODE_SET_ALL;
      else if (sel < 20) mode = ws2812_pkg::MODE_FLUSH;
      else               mode = ws2812_pkg::MODE_TICK;
      send_item(mode, 2'($urandom_range(3)), pick_channel(), pick_channel(), pick_channel());
    end
    quiet_stretch = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    brightness_we_i = 1'b0;
    brightness_i    = 8'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = ws2812_pkg::MODE_TICK;
    m_axis_tready   = 1'b0;
    brightness_now  = ws2812_pkg::BrightnessReset;
    for (int i = 0; i < NumLines; i++) begin
      color_word[i]   = '0;
      pending_word[i] = '0;
      pending_full[i] = 1'b0;
      shift_word[i]   = '0;
      bits_to_send[i] = 0;
      tick_pos[i]     = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_set_colours();
    test_flush_refusal();
    test_brightness_scaling();
    test_random_traffic(8'd255, 1'b0);
    test_random_traffic(8'd0, 1'b0);
    test_random_traffic(8'($urandom_range(255)), 1'b1);
    test_random_traffic(8'd1, 1'b0);
    test_random_traffic(8'($urandom_range(255)), 1'b0);

    // drain, then allow for the pipeline latency
    s_axis_tvalid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
